[hdl/sqltl_pkg.sv]
// Shared types, codes, keyword table and character classes for the SQL token lexer.
package sqltl_pkg;

    // Lexer modes.
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LT     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MINUS  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STRING = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NUMBER = 3'd5;
    localparam logic [MODE_W-1:0] MODE_WORD   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_ERROR  = 3'd7;

    // Token kinds.
    localparam logic [3:0] KIND_END     = 4'd0;
    localparam logic [3:0] KIND_KEYWORD = 4'd1;
    localparam logic [3:0] KIND_IDENT   = 4'd2;
    localparam logic [3:0] KIND_NUMBER  = 4'd3;
    localparam logic [3:0] KIND_STRING  = 4'd4;
    localparam logic [3:0] KIND_LPAREN  = 4'd5;
    localparam logic [3:0] KIND_RPAREN  = 4'd6;
    localparam logic [3:0] KIND_COMMA   = 4'd7;
    localparam logic [3:0] KIND_SEMI    = 4'd8;
    localparam logic [3:0] KIND_STAR    = 4'd9;
    localparam logic [3:0] KIND_EQ      = 4'd10;
    localparam logic [3:0] KIND_LT      = 4'd11;
    localparam logic [3:0] KIND_LE      = 4'd12;
    localparam logic [3:0] KIND_NE      = 4'd13;
    localparam logic [3:0] KIND_GT      = 4'd14;
    localparam logic [3:0] KIND_GE      = 4'd15;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNEXPECT = 2'd1;
    localparam logic [1:0] ERR_UNCLOSED = 2'd2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // Keyword table; text is right-aligned, first character in the highest used byte.
    localparam int KW_SLOTS     = 16;
    localparam int KW_MAX_CHARS = 8;
    localparam logic [63:0] KW_TEXT [KW_SLOTS] = '{
        64'("CREATE"), 64'("TABLE"), 64'("INSERT"), 64'("INTO"),
        64'("VALUES"), 64'("SELECT"), 64'("FROM"), 64'("WHERE"),
        64'("INT"), 64'("INTEGER"), 64'("VARCHAR"), 64'("TEXT"),
        64'h0, 64'h0, 64'h0, 64'h0
    };
    localparam logic [3:0] KW_LEN [KW_SLOTS] = '{
        4'd6, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd4, 4'd5,
        4'd3, 4'd7, 4'd7, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0
    };

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [7:0] char_in;
        logic       stmt_end;
    } char_item_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] text_byte;
        logic       has_byte;
        logic       token_end;
        logic [3:0] keyword_id;
        logic [1:0] error_code;
        logic       last_of_run;
    } token_item_t;

    // Control from the step logic to the state registers and result queue.
    typedef struct packed {
        logic [1:0]        count;
        logic [MODE_W-1:0] mode_next;
        logic              word_start;
        logic              word_add;
    } step_ctl_t;

    function automatic logic [7:0] kw_byte(input int i, input int j);
        logic [63:0] t;
        logic [7:0]  r;
        t = KW_TEXT[i];
        r = 8'h00;
        if (j < int'(KW_LEN[i]))
        begin
            r = t[8*(int'(KW_LEN[i])-1-j) +: 8];
        end
        return r;
    endfunction

    function automatic token_item_t mk_tok(input logic [3:0] kind, input logic [7:0] b,
                                           input logic hb, input logic te,
                                           input logic [3:0] kid, input logic [1:0] err);
        token_item_t t;
        t.token_kind  = kind;
        t.text_byte   = b;
        t.has_byte    = hb;
        t.token_end   = te;
        t.keyword_id  = kid;
        t.error_code  = err;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
    endfunction

endpackage

[hdl/sqltl_kw_match.sv]
// Parallel comparison of the buffered word against the keyword table.
module sqltl_kw_match
    import sqltl_pkg::*;
#(
    parameter int WORD_BUF_LEN  = 7,
    parameter int KEYWORD_COUNT = 12,
    parameter int LEN_W         = $clog2(WORD_BUF_LEN + 1)
)
(
    input  logic [WORD_BUF_LEN-1:0][7:0] word_buf,
    input  logic [LEN_W-1:0]             word_len,
    input  logic                         word_ovf,
    output logic                         hit,
    output logic [3:0]                   kw_id
);

    localparam int CMP_N = (WORD_BUF_LEN < KW_MAX_CHARS) ? WORD_BUF_LEN : KW_MAX_CHARS;

    logic [KEYWORD_COUNT-1:0] match;

    always_comb
    begin
        for (int i = 0; i < KEYWORD_COUNT; i++)
        begin
            match[i] = !word_ovf && (5'(word_len) == 5'(KW_LEN[i]));
            for (int j = 0; j < CMP_N; j++)
            begin
                if ((j < int'(KW_LEN[i])) && (word_buf[j] != kw_byte(i, j)))
                begin
                    match[i] = 1'b0;
                end
            end
        end
    end

    // Lowest matching index wins.
    always_comb
    begin
        kw_id = 4'd0;
        for (int i = KEYWORD_COUNT - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                kw_id = 4'(i);
            end
        end
        hit = |match;
    end

endmodule

[hdl/sqltl_step.sv]
// Per-item lexer decision: results, result count and next mode.
module sqltl_step
    import sqltl_pkg::*;
(
    input  logic [MODE_W-1:0] mode,
    input  char_item_t        item,
    input  logic              kw_hit,
    input  logic [3:0]        kw_id,
    output token_item_t       res0,
    output token_item_t       res1,
    output step_ctl_t         ctl
);

    // Outcome of a byte seen in idle.
    logic              ib_emit;
    token_item_t       ib_res;
    logic [MODE_W-1:0] ib_mode;
    logic              ib_start;

    token_item_t end_tok;
    token_item_t r0;
    token_item_t r1;
    logic [7:0]  c;
    logic        eoi;

    assign c       = item.char_in;
    assign eoi     = item.stmt_end;
    assign end_tok = mk_tok(KIND_END, 8'h00, 1'b0, 1'b1, 4'd0, ERR_NONE);

    always_comb
    begin
        ib_emit  = 1'b1;
        ib_mode  = MODE_IDLE;
        ib_start = 1'b0;
        ib_res   = mk_tok(KIND_END, 8'h00, 1'b0, 1'b1, 4'd0, ERR_NONE);
        case (c)
            CH_LPAREN: ib_res.token_kind = KIND_LPAREN;
            CH_RPAREN: ib_res.token_kind = KIND_RPAREN;
            CH_COMMA:  ib_res.token_kind = KIND_COMMA;
            CH_SEMI:   ib_res.token_kind = KIND_SEMI;
            CH_STAR:   ib_res.token_kind = KIND_STAR;
            CH_EQ:     ib_res.token_kind = KIND_EQ;
            CH_LT:
            begin
                ib_emit = 1'b0;
                ib_mode = MODE_LT;
            end
            CH_GT:
            begin
                ib_emit = 1'b0;
                ib_mode = MODE_GT;
            end
            CH_QUOTE:
            begin
                ib_emit = 1'b0;
                ib_mode = MODE_STRING;
            end
            CH_MINUS:
            begin
                ib_emit = 1'b0;
                ib_mode = MODE_MINUS;
            end
            default:
            begin
                if (is_space(c))
                begin
                    ib_emit = 1'b0;
                end
                else if (is_digit(c))
                begin
                    ib_mode = MODE_NUMBER;
                    ib_res  = mk_tok(KIND_NUMBER, c, 1'b1, 1'b0, 4'd0, ERR_NONE);
                end
                else if (is_alpha(c) || (c == CH_UNDER))
                begin
                    ib_mode  = MODE_WORD;
                    ib_start = 1'b1;
                    ib_res   = mk_tok(KIND_IDENT, c, 1'b1, 1'b0, 4'd0, ERR_NONE);
                end
                else
                begin
                    ib_mode = MODE_ERROR;
                    ib_res  = mk_tok(KIND_END, 8'h00, 1'b0, 1'b1, 4'd0, ERR_UNEXPECT);
                end
            end
        endcase
    end

    always_comb
    begin
        r0             = end_tok;
        r1             = end_tok;
        ctl.count      = 2'd0;
        ctl.mode_next  = mode;
        ctl.word_start = 1'b0;
        ctl.word_add   = 1'b0;

        unique case (mode)
            MODE_ERROR:
            begin
                if (eoi)
                begin
                    ctl.count     = 2'd1;
                    ctl.mode_next = MODE_IDLE;
                end
            end
            MODE_LT, MODE_GT:
            begin
                r0 = mk_tok((mode == MODE_LT) ? KIND_LT : KIND_GT, 8'h00, 1'b0, 1'b1,
                            4'd0, ERR_NONE);
                if (eoi)
                begin
                    ctl.count     = 2'd2;
                    ctl.mode_next = MODE_IDLE;
                end
                else if (c == CH_EQ)
                begin
                    r0.token_kind = (mode == MODE_LT) ? KIND_LE : KIND_GE;
                    ctl.count     = 2'd1;
                    ctl.mode_next = MODE_IDLE;
                end
                else if ((mode == MODE_LT) && (c == CH_GT))
                begin
                    r0.token_kind = KIND_NE;
                    ctl.count     = 2'd1;
                    ctl.mode_next = MODE_IDLE;
                end
                else
                begin
                    r1             = ib_res;
                    ctl.count      = ib_emit ? 2'd2 : 2'd1;
                    ctl.mode_next  = ib_mode;
                    ctl.word_start = ib_start;
                end
            end
            MODE_MINUS:
            begin
                r0 = mk_tok(KIND_END, 8'h00, 1'b0, 1'b1, 4'd0, ERR_UNEXPECT);
                if (eoi)
                begin
                    ctl.count     = 2'd2;
                    ctl.mode_next = MODE_IDLE;
                end
                else if (is_digit(c))
                begin
                    r0            = mk_tok(KIND_NUMBER, CH_MINUS, 1'b1, 1'b0, 4'd0, ERR_NONE);
                    r1            = mk_tok(KIND_NUMBER, c, 1'b1, 1'b0, 4'd0, ERR_NONE);
                    ctl.count     = 2'd2;
                    ctl.mode_next = MODE_NUMBER;
                end
                else
                begin
                    ctl.count     = 2'd1;
                    ctl.mode_next = MODE_ERROR;
                end
            end
            MODE_STRING:
            begin
                ctl.count = 2'd1;
                if (eoi)
                begin
                    r0            = mk_tok(KIND_END, 8'h00, 1'b0, 1'b1, 4'd0, ERR_UNCLOSED);
                    ctl.count     = 2'd2;
                    ctl.mode_next = MODE_IDLE;
                end
                else if (c == CH_QUOTE)
                begin
                    r0            = mk_tok(KIND_STRING, 8'h00, 1'b0, 1'b1, 4'd0, ERR_NONE);
                    ctl.mode_next = MODE_IDLE;
                end
                else
                begin
                    r0 = mk_tok(KIND_STRING, c, 1'b1, 1'b0, 4'd0, ERR_NONE);
                end
            end
            MODE_NUMBER, MODE_WORD:
            begin
                if (!eoi && (mode == MODE_NUMBER) && is_digit(c))
                begin
                    r0        = mk_tok(KIND_NUMBER, c, 1'b1, 1'b0, 4'd0, ERR_NONE);
                    ctl.count = 2'd1;
                end
                else if (!eoi && (mode == MODE_WORD) && is_word(c))
                begin
                    r0           = mk_tok(KIND_IDENT, c, 1'b1, 1'b0, 4'd0, ERR_NONE);
                    ctl.count    = 2'd1;
                    ctl.word_add = 1'b1;
                end
                else
                begin
                    if (mode == MODE_NUMBER)
                    begin
                        r0 = mk_tok(KIND_NUMBER, 8'h00, 1'b0, 1'b1, 4'd0, ERR_NONE);
                    end
                    else if (kw_hit)
                    begin
                        r0 = mk_tok(KIND_KEYWORD, 8'h00, 1'b0, 1'b1, kw_id, ERR_NONE);
                    end
                    else
                    begin
                        r0 = mk_tok(KIND_IDENT, 8'h00, 1'b0, 1'b1, 4'd0, ERR_NONE);
                    end
                    if (eoi)
                    begin
                        ctl.count     = 2'd2;
                        ctl.mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        r1             = ib_res;
                        ctl.count      = ib_emit ? 2'd2 : 2'd1;
                        ctl.mode_next  = ib_mode;
                        ctl.word_start = ib_start;
                    end
                end
            end
            default:
            begin
                if (eoi)
                begin
                    ctl.count     = 2'd1;
                    ctl.mode_next = MODE_IDLE;
                end
                else
                begin
                    r0             = ib_res;
                    ctl.count      = ib_emit ? 2'd1 : 2'd0;
                    ctl.mode_next  = ib_mode;
                    ctl.word_start = ib_start;
                end
            end
        endcase
    end

    // Flag the final result of the item.
    always_comb
    begin
        res0 = r0;
        res1 = r1;
        res0.last_of_run = (ctl.count == 2'd1);
        res1.last_of_run = (ctl.count == 2'd2);
    end

endmodule

[hdl/sqltl_res_queue.sv]
// Four-entry result queue that takes up to two results per cycle and gives one.
module sqltl_res_queue
    import sqltl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  push_count,
    input  token_item_t push0,
    input  token_item_t push1,
    input  logic        pop,
    output logic        room,
    output logic        valid,
    output token_item_t head
);

    token_item_t       q_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg;
    logic [QPTR_W-1:0] head_next;
    logic [QPTR_W-1:0] tail_reg;
    logic [QPTR_W-1:0] tail_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [QPTR_W-1:0] tail_plus1;

    assign tail_plus1 = tail_reg + QPTR_W'(1);
    assign room       = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign valid      = (count_reg != '0);
    assign head       = q_reg[head_reg];
    assign head_next  = pop ? (head_reg + QPTR_W'(1)) : head_reg;
    assign tail_next  = tail_reg + QPTR_W'(push_count);
    assign count_next = count_reg + QCNT_W'(push_count) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QDEPTH; k++)
        begin
            if ((push_count != 2'd0) && (QPTR_W'(k) == tail_reg))
            begin
                q_reg[k] <= push0;
            end
            else if ((push_count == 2'd2) && (QPTR_W'(k) == tail_plus1))
            begin
                q_reg[k] <= push1;
            end
        end
    end

endmodule

[hdl/sql_token_lexer.sv]
// Top level of the streaming SQL token lexer.
//
// The lexer takes one character item per cycle while char_stall is low and
// gives token items. Each accepted item lands in an input register; once
// the queue has room for two results, one pass of shallow logic decides
// its results from the lexer mode and the word buffer, updates the state,
// and writes zero, one or two results into a four-entry result queue that
// drives the token channel. A new character item is taken in every cycle
// while the queue has room for two results, so the sustained rate is one
// item per cycle whenever the items cause at most one result each; an item
// that causes two results (an operator closed by lookahead, a signed
// number, a token closed by end of input) slows the input, since the token
// channel gives one result per cycle. Words keep their first WORD_BUF_LEN
// upper-cased characters for the keyword compare, which runs against all
// KEYWORD_COUNT keywords in parallel when the word ends; longer words are
// never keywords. After an unexpected character the block drops bytes
// until the next end of input item.
module sql_token_lexer
    import sqltl_pkg::*;
#(
    parameter int WORD_BUF_LEN  = 7,
    parameter int KEYWORD_COUNT = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  char_item_t  char_item,
    output logic        token_valid,
    input  logic        token_stall,
    output token_item_t token_item
);

    localparam int LEN_W = $clog2(WORD_BUF_LEN + 1);

    // Input register.
    logic       in_full_reg;
    logic       in_full_next;
    char_item_t in_item_reg;
    logic       char_accept;
    logic       fire;
    logic       q_room;

    // Lexer state.
    logic [MODE_W-1:0]             mode_reg;
    logic [LEN_W-1:0]              word_len_reg;
    logic [LEN_W-1:0]              word_len_next;
    logic                          word_ovf_reg;
    logic                          word_ovf_next;
    logic [WORD_BUF_LEN-1:0][7:0]  word_buf_reg;
    logic                          buf_wr_en;
    logic [LEN_W-1:0]              buf_wr_pos;
    logic [7:0]                    buf_wr_char;

    // Step results.
    logic        kw_hit;
    logic [3:0]  kw_id;
    token_item_t res0;
    token_item_t res1;
    step_ctl_t   ctl;

    // The item in the input register is processed once the queue can take
    // both of its possible results.
    assign fire         = in_full_reg && q_room;
    assign char_stall   = in_full_reg && !fire;
    assign char_accept  = char_valid && !char_stall;
    assign in_full_next = char_accept ? 1'b1 : (fire ? 1'b0 : in_full_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_accept)
        begin
            in_item_reg <= char_item;
        end
    end

    sqltl_kw_match #(
        .WORD_BUF_LEN  (WORD_BUF_LEN),
        .KEYWORD_COUNT (KEYWORD_COUNT),
        .LEN_W         (LEN_W)
    ) u_kw_match (
        .word_buf (word_buf_reg),
        .word_len (word_len_reg),
        .word_ovf (word_ovf_reg),
        .hit      (kw_hit),
        .kw_id    (kw_id)
    );

    sqltl_step u_step (
        .mode   (mode_reg),
        .item   (in_item_reg),
        .kw_hit (kw_hit),
        .kw_id  (kw_id),
        .res0   (res0),
        .res1   (res1),
        .ctl    (ctl)
    );

    // A new word restarts the buffer with its first character; later
    // characters fill the buffer until it is full and then set overflow.
    assign buf_wr_char = to_upper(in_item_reg.char_in);
    assign buf_wr_pos  = ctl.word_start ? '0 : word_len_reg;
    assign buf_wr_en   = fire && (ctl.word_start ||
                         (ctl.word_add && (word_len_reg < LEN_W'(WORD_BUF_LEN))));

    always_comb
    begin
        word_len_next = word_len_reg;
        word_ovf_next = word_ovf_reg;
        if (fire && ctl.word_start)
        begin
            word_len_next = LEN_W'(1);
            word_ovf_next = 1'b0;
        end
        else if (fire && ctl.word_add)
        begin
            if (word_len_reg < LEN_W'(WORD_BUF_LEN))
            begin
                word_len_next = word_len_reg + LEN_W'(1);
            end
            else
            begin
                word_ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            word_len_reg <= '0;
            word_ovf_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                mode_reg <= ctl.mode_next;
            end
            word_len_reg <= word_len_next;
            word_ovf_reg <= word_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < WORD_BUF_LEN; k++)
        begin
            if (buf_wr_en && (buf_wr_pos == LEN_W'(k)))
            begin
                word_buf_reg[k] <= buf_wr_char;
            end
        end
    end

    sqltl_res_queue u_res_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (fire ? ctl.count : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .pop        (token_valid && !token_stall),
        .room       (q_room),
        .valid      (token_valid),
        .head       (token_item)
    );

endmodule
